@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);

// property checked only at edges where cond holds
`define ASSERT_WHEN(lbl, clk_sig, rst_sig, cond, prop, msg) \
  `ASSERT_ALWAYS(lbl, clk_sig, rst_sig, (cond) |-> (prop), msg)

`endif

@@ rtl/cci_pkg.sv @@
package cci_pkg;

  localparam int ROW_COUNT       = 30;
  localparam int STEP_COUNT      = 28;
  localparam int COLUMNS_PER_ROW = 64;

  localparam int ROW_EDGES  = 29;
  localparam int STEP_EDGES = 27;

  localparam logic [29:0]        FREQ_MIN = 30'd100000;
  localparam logic [29:0]        FREQ_MAX = 30'd560000000;
  localparam logic signed [15:0] AMP_MIN  = -16'sd1299;
  localparam logic signed [15:0] AMP_MAX  = 16'sd130;

  typedef struct packed {
    logic       ok;
    logic [4:0] row;
    logic [4:0] step;
  } cell_loc_t;

  // lowest frequency of each row after the first
  function automatic logic [29:0] row_edge(input int i);
    int v;
    if (i < 8) begin
      v = 100000 * (i + 2);
    end else if (i < 17) begin
      v = 1000000 * (i - 7);
    end else begin
      v = 10000000 + 50000000 * (i - 17);
    end
    return 30'(v);
  endfunction

  // highest level that still needs more than k attenuator steps
  function automatic logic signed [15:0] step_edge(input int k);
    return 16'(19 - 50 * k);
  endfunction

endpackage

@@ rtl/calibration_correction_index.sv @@
// channel  | handshake             | fields
// input    | in_valid / in_stall   | frequency_hz, amplitude_tenths_dbm
// output   | out_valid / out_stall | index_valid, table_index, compact_index,
//          |                       | freq_row, atten_step
//
// one item per cycle while out_stall is low, three register stages (s1, s2, output register) between accept and outputs
// stage 1 compares against band edges, stage 2 counts edges, stage 3 forms addresses
// synchronous reset empties all three stages
// out_stall holds each stage that is full; empty stages keep filling
`include "assert_macros.svh"

module calibration_correction_index (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [29:0]         frequency_hz,
  input  logic signed [15:0]  amplitude_tenths_dbm,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                index_valid,
  output logic [10:0]         table_index,
  output logic [9:0]          compact_index,
  output logic [4:0]          freq_row,
  output logic [4:0]          atten_step
);
  import cci_pkg::*;

  logic      loc_valid;
  logic      loc_stall;
  cell_loc_t loc;
  logic      out_ready;
  logic [10:0] table_index_next;
  logic [9:0]  compact_index_next;

  cci_locate u_locate (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .frequency_hz         (frequency_hz),
    .amplitude_tenths_dbm (amplitude_tenths_dbm),
    .loc_valid            (loc_valid),
    .loc_stall            (loc_stall),
    .loc                  (loc)
  );

  assign out_ready = !out_valid || !out_stall;
  assign loc_stall = !out_ready;

  always_comb begin
    table_index_next   = 11'(loc.row * 11'(COLUMNS_PER_ROW) + 11'(loc.step));
    compact_index_next = 10'(loc.row * 10'(STEP_COUNT) + 10'(loc.step));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= loc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && loc_valid) begin
      index_valid   <= loc.ok;
      table_index   <= loc.ok ? table_index_next : 11'd0;
      compact_index <= loc.ok ? compact_index_next : 10'd0;
      freq_row      <= loc.ok ? loc.row : 5'd0;
      atten_step    <= loc.ok ? loc.step : 5'd0;
    end
  end

  `ASSERT_WHEN(a_zero_when_invalid, clk, rst, out_valid && !index_valid, (table_index == 11'd0) && (compact_index == 10'd0) && (freq_row == 5'd0) && (atten_step == 5'd0), "invalid item carries nonzero fields")
  `ASSERT_WHEN(a_cell_in_range, clk, rst, out_valid && index_valid, (freq_row < 5'(ROW_COUNT)) && (atten_step < 5'(STEP_COUNT)), "row or step beyond table")
  `ASSERT_WHEN(a_index_match, clk, rst, out_valid && index_valid, compact_index == 10'(freq_row * 10'(STEP_COUNT) + 10'(atten_step)), "compact index disagrees with row and step")

endmodule

@@ rtl/cci_locate.sv @@
module cci_locate (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [29:0]            frequency_hz,
  input  logic signed [15:0]     amplitude_tenths_dbm,
  output logic                   loc_valid,
  input  logic                   loc_stall,
  output cci_pkg::cell_loc_t     loc
);
  import cci_pkg::*;

  logic                  s1_valid;
  logic [ROW_EDGES-1:0]  s1_row_hits;
  logic [STEP_EDGES-1:0] s1_step_hits;
  logic                  s1_in_range;
  logic [ROW_EDGES-1:0]  row_hits_next;
  logic [STEP_EDGES-1:0] step_hits_next;
  logic                  in_range_next;
  logic                  s1_ready;
  logic                  s2_ready;
  logic                  s2_valid;
  cell_loc_t             s2_loc;
  cell_loc_t             s2_loc_next;

  assign s2_ready = !s2_valid || !loc_stall;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  // stage 1: compare against every band edge
  always_comb begin
    for (int i = 0; i < ROW_EDGES; i++) begin
      row_hits_next[i] = frequency_hz >= row_edge(i);
    end
    for (int k = 0; k < STEP_EDGES; k++) begin
      step_hits_next[k] = amplitude_tenths_dbm <= step_edge(k);
    end
    in_range_next = (frequency_hz >= FREQ_MIN) && (frequency_hz <= FREQ_MAX) &&
                    (amplitude_tenths_dbm >= AMP_MIN) && (amplitude_tenths_dbm <= AMP_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_row_hits  <= row_hits_next;
      s1_step_hits <= step_hits_next;
      s1_in_range  <= in_range_next;
    end
  end

  // stage 2: edge counts give row and step
  always_comb begin
    s2_loc_next.row  = 5'($countones(s1_row_hits));
    s2_loc_next.step = 5'($countones(s1_step_hits));
    s2_loc_next.ok   = s1_in_range &&
                       (s2_loc_next.row < 5'(ROW_COUNT)) &&
                       (s2_loc_next.step < 5'(STEP_COUNT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_loc <= s2_loc_next;
    end
  end

  assign loc_valid = s2_valid;
  assign loc       = s2_loc;

endmodule
